>>> rtl/core/aobt_pkg.sv
// ----------------------------------------------------------------------------
// aobt_pkg
// shared constants, types and helpers for the binomial option pricer
// ----------------------------------------------------------------------------
package aobt_pkg;

   localparam int MaxSteps   = 256;
   localparam int Lanes      = MaxSteps + 1;
   localparam int AddrW      = $clog2(Lanes);
   localparam int StepW      = 9;
   localparam int FactorFrac = 30;

   localparam logic [0:0] CSR_STEP_COUNT   = 1'b0;
   localparam logic [0:0] CSR_STRIKE_PRICE = 1'b1;

   // datapath operations
   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_CENTER = 3'd1;  // write centre leaf
   localparam logic [2:0] OP_UPLEAF = 3'd2;  // leaf j from leaf j-1 times u*u
   localparam logic [2:0] OP_DNLEAF = 3'd3;  // leaf j-1 from leaf j times d*d
   localparam logic [2:0] OP_SEED   = 3'd4;  // payoff of leaf j
   localparam logic [2:0] OP_NODE   = 3'd5;  // interior node update

   typedef struct packed {
      logic             start;
      logic [2:0]       op;
      logic [AddrW-1:0] idx;
      logic             odd;
      logic             up_side;
   } cmd_type;

   typedef struct packed {
      logic busy;
   } status_type;

   function automatic logic [31:0] sat32(input logic [63:0] v);
      sat32 = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   function automatic logic [31:0] payoff(input logic [31:0] price,
                                          input logic [31:0] strike,
                                          input logic call);
      logic [31:0] r;
      r = 32'd0;
      if (call) begin
         if (price > strike) r = price - strike;
      end else begin
         if (strike > price) r = strike - price;
      end
      payoff = r;
   endfunction

endpackage

>>> rtl/core/aobt_datapath.sv
// ----------------------------------------------------------------------------
// aobt_datapath
// node memories, shared multiplier and node arithmetic, one op at a time
// ----------------------------------------------------------------------------
module aobt_datapath (
   input  logic                clock,
   input  logic                reset,
   input  aobt_pkg::cmd_type   cmd,
   input  logic [31:0]         spot_price,
   input  logic [31:0]         up_factor,
   input  logic [31:0]         down_factor,
   input  logic [31:0]         discount_factor,
   input  logic [30:0]         up_probability,
   input  logic                call_not_put,
   input  logic [31:0]         strike,
   output aobt_pkg::status_type status,
   output logic [31:0]         root_value
);
   import aobt_pkg::*;

   logic [31:0] price_mem [Lanes];
   logic [31:0] value_mem [Lanes];

   logic [31:0] s0_ff, u_ff, d_ff, disc_ff;
   logic [30:0] q_ff;
   logic        call_ff;

   // micro sequencer for one op
   logic [3:0]       ph_ff, ph_in;
   logic [2:0]       op_ff;
   logic [AddrW-1:0] idx_ff;
   logic             odd_ff, up_ff;

   logic [31:0] ma_ff, mb_ff, prod_ff;
   logic [31:0] rd0_ff, rd1_ff, vr0_ff, vr1_ff, tmp_ff, price_ff;
   logic [AddrW-1:0] ra0, ra1;
   logic [31:0] mul_res;
   logic [63:0] mix_ff;
   logic [31:0] root_ff;

   assign mul_res = sat32(({32'd0, ma_ff} * {32'd0, mb_ff}) >> FactorFrac);
   assign status.busy = (ph_ff != 4'd0);
   assign root_value = root_ff;

   always_comb begin
      ra0 = idx_ff;
      ra1 = idx_ff + AddrW'(1);
      if (op_ff == OP_UPLEAF) ra0 = idx_ff - AddrW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) ph_ff <= 4'd0;
      else       ph_ff <= ph_in;
   end

   always_comb begin
      ph_in = ph_ff;
      if (ph_ff == 4'd0) begin
         if (cmd.op != OP_NONE) ph_in = 4'd1;
      end else if (ph_ff == 4'd9) ph_in = 4'd0;
      else ph_in = ph_ff + 4'd1;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         s0_ff <= spot_price;  u_ff <= up_factor;  d_ff <= down_factor;
         disc_ff <= discount_factor;
         q_ff <= (up_probability > 31'h4000_0000) ? 31'h4000_0000 : up_probability;
         call_ff <= call_not_put;
      end
      if (ph_ff == 4'd0) begin
         op_ff <= cmd.op; idx_ff <= cmd.idx; odd_ff <= cmd.odd; up_ff <= cmd.up_side;
      end
      // phase 1: memory reads registered
      rd0_ff <= price_mem[ra0];
      rd1_ff <= price_mem[ra1];
      vr0_ff <= value_mem[ra0];
      vr1_ff <= value_mem[ra1];
      prod_ff <= mul_res;
      unique case (ph_ff)
         4'd2: begin
            unique case (op_ff)
               OP_CENTER: begin ma_ff <= s0_ff; mb_ff <= d_ff; end
               OP_UPLEAF: begin ma_ff <= rd0_ff; mb_ff <= u_ff; end
               OP_DNLEAF: begin ma_ff <= rd0_ff; mb_ff <= d_ff; end
               OP_NODE: begin
                  ma_ff <= up_ff ? rd0_ff : rd1_ff;
                  mb_ff <= up_ff ? u_ff : d_ff;
               end
               default: begin ma_ff <= rd0_ff; mb_ff <= d_ff; end
            endcase
            mix_ff <= {33'd0, q_ff} * {32'd0, vr1_ff};
         end
         4'd4: begin
            tmp_ff <= prod_ff;
            ma_ff <= prod_ff;
            mix_ff <= mix_ff + ({32'd0, 32'h4000_0000 - {1'b0, q_ff}} * {32'd0, vr0_ff});
         end
         4'd5: begin
            // second multiply: leaf squared factor, or discount of continuation
            price_ff <= tmp_ff;
            if (op_ff == OP_NODE) begin
               ma_ff <= sat32(mix_ff >> FactorFrac);
               mb_ff <= disc_ff;
            end
         end
         4'd7: begin
            unique case (op_ff)
               OP_CENTER:
                  price_mem[idx_ff] <= odd_ff ? price_ff : s0_ff;
               OP_UPLEAF: price_mem[idx_ff] <= prod_ff;
               OP_DNLEAF: price_mem[idx_ff - AddrW'(1)] <= prod_ff;
               OP_SEED: value_mem[idx_ff] <= payoff(rd0_ff, strike, call_ff);
               OP_NODE: begin
                  price_mem[idx_ff] <= price_ff;
                  value_mem[idx_ff] <= (payoff(price_ff, strike, call_ff) > prod_ff)
                     ? payoff(price_ff, strike, call_ff) : prod_ff;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      // value of the node just written, read back; the last op is the root
      if (ph_ff == 4'd9) root_ff <= vr0_ff;
   end

endmodule

>>> rtl/core/aobt_ctrl.sv
// ----------------------------------------------------------------------------
// aobt_ctrl
// sequencer over leaf build, payoff seed and backward induction
// ----------------------------------------------------------------------------
module aobt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [8:0]           steps,
   input  aobt_pkg::status_type status,
   output aobt_pkg::cmd_type    cmd
);
   import aobt_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0, S_CTR = 3'd1, S_UP = 3'd2, S_DN = 3'd3,
                          S_SEED = 3'd4, S_NODE = 3'd5, S_LAST = 3'd6, S_OUT = 3'd7;

   logic [2:0]       st_ff, st_in;
   logic [AddrW-1:0] n_ff, n_in, j_ff, j_in, t_ff, t_in, c_ff, c_in;
   logic             issued_ff, issued_in;
   logic [StepW-1:0] nsat;
   logic             take;

   always_comb begin
      nsat = steps;
      if (steps == 9'd0) nsat = 9'd1;
      else if (steps > 9'(MaxSteps)) nsat = 9'(MaxSteps);
   end

   assign take      = req_valid && (st_ff == S_IDLE);
   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = (st_ff == S_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; issued_ff <= 1'b0;
      end else begin
         st_ff <= st_in; issued_ff <= issued_in;
      end
      n_ff <= n_in; j_ff <= j_in; t_ff <= t_in; c_ff <= c_in;
   end

   // one op issued at a time; advance once the datapath finishes
   always_comb begin
      logic done;
      st_in = st_ff; n_in = n_ff; j_in = j_ff; t_in = t_ff; c_in = c_ff;
      issued_in = issued_ff;
      cmd = '0;
      cmd.start = take;
      cmd.odd = n_ff[0];
      cmd.idx = j_ff;
      done = issued_ff && !status.busy;
      unique case (st_ff)
         S_IDLE: begin
            if (take) begin
               n_in = nsat[AddrW-1:0];
               c_in = AddrW'(nsat[AddrW-1:1]);
               j_in = AddrW'(nsat[AddrW-1:1]);
               st_in = S_CTR;
            end
         end
         S_OUT: if (!rsp_stall) st_in = S_IDLE;
         default: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
               unique case (st_ff)
                  S_CTR:  cmd.op = OP_CENTER;
                  S_UP:   cmd.op = OP_UPLEAF;
                  S_DN:   cmd.op = OP_DNLEAF;
                  S_SEED: cmd.op = OP_SEED;
                  S_NODE: begin
                     cmd.op = OP_NODE;
                     cmd.up_side = ({1'b0, j_ff, 1'b0} > {2'b0, t_ff});
                  end
                  default: cmd.op = OP_NONE;
               endcase
            end else if (done) begin
               issued_in = 1'b0;
               unique case (st_ff)
                  S_CTR: begin
                     j_in = c_ff + AddrW'(1);
                     st_in = (c_ff == n_ff) ? S_DN : S_UP;
                     if (c_ff == n_ff) j_in = c_ff;
                     if (c_ff == n_ff && c_ff == '0) begin st_in = S_SEED; end
                  end
                  S_UP: begin
                     if (j_ff == n_ff) begin
                        j_in = c_ff;
                        st_in = (c_ff == '0) ? S_SEED : S_DN;
                     end else j_in = j_ff + AddrW'(1);
                  end
                  S_DN: begin
                     if (j_ff == AddrW'(1)) begin j_in = '0; st_in = S_SEED; end
                     else j_in = j_ff - AddrW'(1);
                  end
                  S_SEED: begin
                     if (j_ff == n_ff) begin
                        j_in = '0; t_in = n_ff - AddrW'(1); st_in = S_NODE;
                     end else j_in = j_ff + AddrW'(1);
                  end
                  S_NODE: begin
                     if (j_ff == t_ff) begin
                        j_in = '0;
                        if (t_ff == '0) st_in = S_LAST;
                        else t_in = t_ff - AddrW'(1);
                     end else j_in = j_ff + AddrW'(1);
                  end
                  default: st_in = S_OUT;
               endcase
            end
         end
      endcase
      // last: a no-op step; the root value was latched at the end of the last node op
      if (st_ff == S_LAST && done) st_in = S_OUT;
   end

endmodule

>>> rtl/core/american_option_binomial_tree.sv
// ----------------------------------------------------------------------------
// american_option_binomial_tree
// American put/call pricer on a Cox-Ross-Rubinstein lattice
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  req_    | in        | req_valid / req_stall, six payload fields
//  rsp_    | out       | rsp_valid / rsp_stall, option_value
//  csr_    | in        | csr_valid / csr_ready, csr_index, csr_data
//
// every node, leaf build and payoff seed is one datapath op through the shared
// multiplier, and the ops run one at a time.
// reset is synchronous and clears control state; node memories are not cleared.
// one item at a time: req_stall is high until the result transfer completes.
module american_option_binomial_tree (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_spot_price,
   input  logic [31:0] req_up_factor,
   input  logic [31:0] req_down_factor,
   input  logic [31:0] req_discount_factor,
   input  logic [30:0] req_up_probability,
   input  logic        req_call_not_put,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_option_value,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   import aobt_pkg::*;

   logic [8:0]  steps_ff;
   logic [31:0] strike_ff;
   cmd_type     cmd;
   status_type  status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= 9'd64; strike_ff <= 32'd0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_STEP_COUNT:   steps_ff  <= csr_data[8:0];
            CSR_STRIKE_PRICE: strike_ff <= csr_data;
            default: ;
         endcase
      end
   end

   aobt_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .steps(steps_ff), .status, .cmd
   );

   aobt_datapath u_dp (
      .clock, .reset, .cmd,
      .spot_price(req_spot_price), .up_factor(req_up_factor),
      .down_factor(req_down_factor), .discount_factor(req_discount_factor),
      .up_probability(req_up_probability), .call_not_put(req_call_not_put),
      .strike(strike_ff), .status, .root_value(rsp_option_value)
   );

endmodule

>>> rtl/core/aobt_checker.sv
// ----------------------------------------------------------------------------
// aobt_checker
// port-level checks on the pricer handshakes
// ----------------------------------------------------------------------------
module aobt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_option_value
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken with result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_option_value))
      else $error("result changed while stalled");
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("not busy after request transfer");
endmodule

bind american_option_binomial_tree aobt_checker u_aobt_checker (
   .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .rsp_option_value
);
